/* hdl/tta_pkg.sv */
//------------------------------------------------------------------------------
// tta_pkg
// Shared types and constants for the triangle tangent accumulator.
//------------------------------------------------------------------------------
package tta_pkg;

	localparam int VERTEX_COUNT = 1024;
	localparam int VIDX_W       = 10;
	localparam int POS_W        = 24;
	localparam int UV_W         = 16;
	localparam int VAL_W        = 32;
	localparam int NUM_W        = 64;
	localparam int DEN_W        = 34;
	localparam int QUO_W        = 48;

	typedef struct packed {
		logic [VIDX_W-1:0]       vertex_index;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic signed [UV_W-1:0]  tex_u;
		logic signed [UV_W-1:0]  tex_v;
	} in_item_t;

	typedef struct packed {
		logic [VIDX_W-1:0]       out_index;
		logic signed [VAL_W-1:0] tangent_x;
		logic signed [VAL_W-1:0] tangent_y;
		logic signed [VAL_W-1:0] tangent_z;
		logic signed [VAL_W-1:0] bitangent_x;
		logic signed [VAL_W-1:0] bitangent_y;
		logic signed [VAL_W-1:0] bitangent_z;
		logic                    degenerate;
		logic                    last_of_triangle;
	} out_item_t;

	function automatic logic signed [VAL_W-1:0] half_sum(
		input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] b
	);
		logic signed [VAL_W:0] s;
		s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
		return s[VAL_W:1];
	endfunction

endpackage

/* hdl/tta_divider.sv */
//------------------------------------------------------------------------------
// tta_divider
// Restoring divider, one quotient bit per cycle, with round-half-away and
// saturation to signed 32 bits.
//------------------------------------------------------------------------------
module tta_divider (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [tta_pkg::NUM_W-1:0]     num,
	input  logic signed [tta_pkg::DEN_W-1:0]     den,
	output logic                                 done,
	output logic signed [tta_pkg::VAL_W-1:0]     quo
);

	localparam int NW = tta_pkg::NUM_W;
	localparam int DW = tta_pkg::DEN_W;
	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] a_q;
	logic [DW-1:0] b_q;
	logic [DW:0]   rem_q;
	logic          neg_q;
	logic [DW:0]   trial;
	logic [DW:0]   rem_next;
	logic [NW-1:0] q_up;
	logic [DW:0]   twice_r;
	logic          rnd;
	logic [NW:0]   qr;

	always_comb begin
		trial    = {rem_q[DW-1:0], a_q[NW-1]};
		rem_next = (trial >= {1'b0, b_q}) ? trial - {1'b0, b_q} : trial;
		twice_r  = {rem_q[DW-1:0], 1'b0};
		rnd      = twice_r >= {1'b0, b_q};
		q_up     = a_q;
		qr       = {1'b0, q_up} + {{NW{1'b0}}, rnd};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// a_q shifts dividend out at the top and quotient bits in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= num[NW-1] ? NW'(-num) : num;
			b_q   <= den[DW-1] ? DW'(-den) : den;
			neg_q <= num[NW-1] ^ den[DW-1];
			rem_q <= '0;
		end else if (busy_q && cnt_q != '0) begin
			rem_q <= rem_next;
			a_q   <= {a_q[NW-2:0], (trial >= {1'b0, b_q})};
		end else if (busy_q) begin
			if (!neg_q) begin
				quo <= (qr > (NW+1)'(32'h7fffffff)) ? 32'sh7fffffff : qr[31:0];
			end else begin
				quo <= (qr > (NW+1)'(33'h80000000)) ? 32'sh80000000 : 32'(-qr[31:0]);
			end
		end
	end

endmodule

/* hdl/triangle_tangent_accumulator.sv */
//------------------------------------------------------------------------------
// triangle_tangent_accumulator
// Per-vertex tangent/bitangent accumulation from triangle corners.
//------------------------------------------------------------------------------
// After reset the block clears its vertex store; in_ready stays low until that
// is done. The first two corners of a triangle are only stored. The third
// corner is stored, then the UV determinant and six numerators are computed,
// then six divisions run through one shared bit-serial divider (skipped when
// the determinant is zero), then the three corners are updated in order with a
// read-modify-write of the vertex store (a 1024-deep memory with a registered
// read); each corner waits while the receiver stalls. Each corner's result is
// held in an output register until taken. Visited marks share the store word.
module triangle_tangent_accumulator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tta_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tta_pkg::out_item_t  out_data
);

	localparam int VC = tta_pkg::VERTEX_COUNT;
	localparam int AW = $clog2(VC);
	localparam int VW = tta_pkg::VAL_W;
	localparam int SW = 6 * VW + 1;

	typedef enum logic [7:0] {
		ST_CLEAR   = 8'b00000001,
		ST_COLLECT = 8'b00000010,
		ST_MUL     = 8'b00000100,
		ST_DIV     = 8'b00001000,
		ST_WAIT    = 8'b00010000,
		ST_READ    = 8'b00100000,
		ST_WRITE   = 8'b01000000,
		ST_OUT     = 8'b10000000
	} state_t;

	state_t state_q;
	logic [1:0] phase_q;
	logic [1:0] corner_q;
	logic [2:0] dsel_q;
	logic [AW-1:0] clr_q;
	logic [2:0] was_q;
	logic was_cur;

	logic signed [tta_pkg::POS_W-1:0] p0_q [3];
	logic signed [tta_pkg::POS_W-1:0] p1_q [3];
	logic signed [tta_pkg::POS_W-1:0] p2_q [3];
	logic signed [tta_pkg::UV_W-1:0]  uv0_q [2];
	logic signed [tta_pkg::UV_W-1:0]  uv1_q [2];
	logic signed [tta_pkg::UV_W-1:0]  uv2_q [2];
	logic [tta_pkg::VIDX_W-1:0] idx_q [3];

	logic signed [tta_pkg::DEN_W-1:0] det_q;
	logic signed [tta_pkg::NUM_W-1:0] num_q [6];
	logic signed [VW-1:0] res_q [6];
	logic degen_q;

	// store: visited mark on top of six 32-bit words per vertex
	logic [SW-1:0] store_mem [VC];
	logic [SW-1:0] rd_s1;
	logic [SW-1:0] wr_data;
	logic signed [VW-1:0] newv [6];

	logic div_start, div_done;
	logic signed [VW-1:0] div_quo;

	logic signed [tta_pkg::POS_W:0] d1 [3];
	logic signed [tta_pkg::POS_W:0] d2 [3];
	logic signed [tta_pkg::UV_W:0]  e1 [2];
	logic signed [tta_pkg::UV_W:0]  e2 [2];

	logic [tta_pkg::VIDX_W-1:0] cur_idx;
	logic cur_in_range;

	function automatic logic signed [tta_pkg::DEN_W-1:0] DEN_W_mul(
		input logic signed [tta_pkg::UV_W:0] a,
		input logic signed [tta_pkg::UV_W:0] b
	);
		return tta_pkg::DEN_W'(a * b);
	endfunction

	function automatic logic det_next_zero();
		logic signed [tta_pkg::DEN_W-1:0] d;
		d = DEN_W_mul(e1[0], e2[1]) - DEN_W_mul(e1[1], e2[0]);
		return d == '0;
	endfunction

	function automatic logic signed [tta_pkg::NUM_W-1:0] num_of(
		input logic signed [tta_pkg::POS_W:0] x,
		input logic signed [tta_pkg::UV_W:0]  ex,
		input logic signed [tta_pkg::POS_W:0] y,
		input logic signed [tta_pkg::UV_W:0]  ey
	);
		logic signed [tta_pkg::NUM_W-1:0] px;
		logic signed [tta_pkg::NUM_W-1:0] py;
		px = tta_pkg::NUM_W'(x * ex);
		py = tta_pkg::NUM_W'(y * ey);
		return (px - py) <<< 12;
	endfunction

	assign in_ready = (state_q == ST_COLLECT) && !out_valid;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			d1[k] = {p1_q[k][tta_pkg::POS_W-1], p1_q[k]} - {p0_q[k][tta_pkg::POS_W-1], p0_q[k]};
			d2[k] = {p2_q[k][tta_pkg::POS_W-1], p2_q[k]} - {p0_q[k][tta_pkg::POS_W-1], p0_q[k]};
		end
		for (int k = 0; k < 2; k++) begin
			e1[k] = {uv1_q[k][tta_pkg::UV_W-1], uv1_q[k]} - {uv0_q[k][tta_pkg::UV_W-1], uv0_q[k]};
			e2[k] = {uv2_q[k][tta_pkg::UV_W-1], uv2_q[k]} - {uv0_q[k][tta_pkg::UV_W-1], uv0_q[k]};
		end
	end

	assign cur_idx      = idx_q[corner_q];
	assign cur_in_range = {1'b0, cur_idx} < (tta_pkg::VIDX_W+1)'(VC);

	// a repeat of an earlier corner keeps that corner's mark from before the triangle
	always_comb begin
		was_cur = rd_s1[SW-1];
		if (corner_q == 2'd1 && idx_q[1] == idx_q[0])
			was_cur = was_q[0];
		else if (corner_q == 2'd2 && idx_q[2] == idx_q[0])
			was_cur = was_q[0];
		else if (corner_q == 2'd2 && idx_q[2] == idx_q[1])
			was_cur = was_q[1];
	end

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			if (was_cur && cur_in_range)
				newv[k] = tta_pkg::half_sum(rd_s1[k*VW +: VW], res_q[k]);
			else
				newv[k] = res_q[k];
			wr_data[k*VW +: VW] = newv[k];
		end
		wr_data[SW-1] = 1'b1;
	end

	assign div_start = (state_q == ST_DIV);

	tta_divider u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (num_q[dsel_q]),
		.den   (det_q),
		.done  (div_done),
		.quo   (div_quo)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_READ)
			rd_s1 <= store_mem[cur_idx[AW-1:0]];
		if (state_q == ST_CLEAR)
			store_mem[clr_q] <= '0;
		else if (state_q == ST_WRITE && cur_in_range)
			store_mem[cur_idx[AW-1:0]] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			phase_q   <= '0;
			corner_q  <= '0;
			dsel_q    <= '0;
			clr_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(VC - 1))
						state_q <= ST_COLLECT;
				end
				ST_COLLECT: begin
					if (in_valid && in_ready) begin
						if (phase_q == 2'd2) begin
							phase_q <= '0;
							state_q <= ST_MUL;
						end else begin
							phase_q <= phase_q + 1'b1;
						end
					end
				end
				ST_MUL: begin
					dsel_q  <= '0;
					corner_q <= '0;
					state_q <= (det_next_zero()) ? ST_READ : ST_DIV;
				end
				ST_DIV: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (div_done) begin
						if (dsel_q == 3'd5) begin
							state_q <= ST_READ;
						end else begin
							dsel_q  <= dsel_q + 1'b1;
							state_q <= ST_DIV;
						end
					end
				end
				ST_READ: state_q <= ST_WRITE;
				ST_WRITE: begin
					out_valid <= 1'b1;
					state_q   <= ST_OUT;
				end
				ST_OUT: begin
					if (out_valid && out_ready) begin
						if (corner_q == 2'd2) begin
							state_q <= ST_COLLECT;
						end else begin
							corner_q <= corner_q + 1'b1;
							state_q  <= ST_READ;
						end
					end
				end
				default: state_q <= ST_COLLECT;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			case (phase_q)
				2'd0: begin
					p0_q[0] <= in_data.pos_x; p0_q[1] <= in_data.pos_y; p0_q[2] <= in_data.pos_z;
					uv0_q[0] <= in_data.tex_u; uv0_q[1] <= in_data.tex_v;
					idx_q[0] <= in_data.vertex_index;
				end
				2'd1: begin
					p1_q[0] <= in_data.pos_x; p1_q[1] <= in_data.pos_y; p1_q[2] <= in_data.pos_z;
					uv1_q[0] <= in_data.tex_u; uv1_q[1] <= in_data.tex_v;
					idx_q[1] <= in_data.vertex_index;
				end
				default: begin
					p2_q[0] <= in_data.pos_x; p2_q[1] <= in_data.pos_y; p2_q[2] <= in_data.pos_z;
					uv2_q[0] <= in_data.tex_u; uv2_q[1] <= in_data.tex_v;
					idx_q[2] <= in_data.vertex_index;
				end
			endcase
		end
		if (state_q == ST_MUL) begin
			det_q   <= DEN_W_mul(e1[0], e2[1]) - DEN_W_mul(e1[1], e2[0]);
			degen_q <= det_next_zero();
			for (int k = 0; k < 3; k++) begin
				num_q[k]     <= num_of(d1[k], e2[1], d2[k], e1[1]);
				num_q[k + 3] <= num_of(d2[k], e1[0], d1[k], e2[0]);
				res_q[k]     <= '0;
				res_q[k + 3] <= '0;
			end
		end
		if (state_q == ST_WAIT && div_done)
			res_q[dsel_q] <= div_quo;
		if (state_q == ST_WRITE) begin
			was_q[corner_q]           <= was_cur;
			out_data.out_index        <= cur_idx;
			out_data.tangent_x        <= newv[0];
			out_data.tangent_y        <= newv[1];
			out_data.tangent_z        <= newv[2];
			out_data.bitangent_x      <= newv[3];
			out_data.bitangent_y      <= newv[4];
			out_data.bitangent_z      <= newv[5];
			out_data.degenerate       <= degen_q;
			out_data.last_of_triangle <= (corner_q == 2'd2);
		end
	end

`ifndef ASSERT_OFF
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_COLLECT) |-> !in_ready) else $error("input taken while busy");
	a_out_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_WRITE)) else $error("stray result");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.last_of_triangle == (corner_q == 2'd2)))
		else $error("last flag mismatch");
`endif

endmodule
